// File: sv/bgs_pkg.sv
`timescale 1ns / 1ps
package bgs_pkg;

  localparam int SRC_MAX_W_DEF = 128;
  localparam int SRC_MAX_H_DEF = 64;
  localparam int DST_MAX_W_DEF = 256;
  localparam int DST_MAX_H_DEF = 256;
  localparam int FRAC_BITS_DEF = 8;

  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int DEN_W      = 9;

  localparam logic [7:0] WHITE      = 8'd255;
  localparam logic [7:0] THRESH_RST = 8'd160;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_THRESHOLD  = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] pix;
  } item_t;

endpackage

// File: sv/bgs_if.sv
`timescale 1ns / 1ps
interface bgs_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] coord_x;
  logic [7:0] coord_y;
  logic [7:0] pixel_in;

  modport source (output valid, operation, coord_x, coord_y, pixel_in, input ready);
  modport sink (input valid, operation, coord_x, coord_y, pixel_in, output ready);
endinterface

interface bgs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic [7:0] out_x;
  logic [7:0] out_y;

  modport source (output valid, pixel_out, out_x, out_y, input ready);
  modport sink (input valid, pixel_out, out_x, out_y, output ready);
endinterface

// File: sv/bgs_div.sv
`timescale 1ns / 1ps
module bgs_div #(
  parameter int NW = 24,
  parameter int DB = 9
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DB-1:0] den,
  output logic [NW-1:0] quot
);

  logic [DB-1:0] rem [NW];
  logic [NW-1:0] nr  [NW];
  logic [NW-1:0] qr  [NW];

  // one quotient bit per stage, restoring form
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DB-1:0] rin;
    logic [NW-1:0] nin;
    logic [NW-1:0] qin;
    logic [DB:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rin = '0;
      assign nin = num;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[k-1];
      assign nin = nr[k-1];
      assign qin = qr[k-1];
    end

    assign trial = {rin, nin[NW-1]};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DB'(trial - {1'b0, den}) : DB'(trial);
        nr[k]  <= nin << 1;
        qr[k]  <= {qin[NW-2:0], ge};
      end
    end
  end

  assign quot = qr[NW-1];

endmodule

// File: sv/bgs_store.sv
`timescale 1ns / 1ps
module bgs_store #(
  parameter int SRC_MAX_W = bgs_pkg::SRC_MAX_W_DEF,
  parameter int SRC_MAX_H = bgs_pkg::SRC_MAX_H_DEF,
  parameter int FRAC_BITS = bgs_pkg::FRAC_BITS_DEF,
  parameter int NW        = 16 + FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  bgs_pkg::item_t       in_item,
  input  logic [NW-1:0]        qx,
  input  logic [NW-1:0]        qy,
  input  logic [7:0]           sw,
  input  logic [6:0]           sh,
  output logic                 nb_valid,
  output bgs_pkg::item_t       nb_item,
  output logic [7:0]           nb [4],
  output logic [FRAC_BITS-1:0] nb_xf,
  output logic [FRAC_BITS-1:0] nb_yf
);

  localparam int HW = (SRC_MAX_W + 1) / 2;
  localparam int HH = (SRC_MAX_H + 1) / 2;
  localparam int BD = HW * HH;
  localparam int AW = (BD > 1) ? $clog2(BD) : 1;
  localparam int XB = NW - FRAC_BITS;

  logic [XB-1:0] x0, y0;
  logic [XB:0]   xn [2];
  logic [XB:0]   yn [2];
  logic          inx [2];
  logic          iny [2];
  logic [AW-1:0] ra_next [4];
  logic          ld_ok;

  assign x0 = qx[NW-1:FRAC_BITS];
  assign y0 = qy[NW-1:FRAC_BITS];

  // bank b of a dimension holds the neighbour whose parity is b
  for (genvar b = 0; b < 2; b++) begin : g_coord
    assign xn[b]  = {1'b0, x0} + (XB+1)'(x0[0] ^ b[0]);
    assign yn[b]  = {1'b0, y0} + (XB+1)'(y0[0] ^ b[0]);
    assign inx[b] = xn[b] < (XB+1)'(sw);
    assign iny[b] = yn[b] < (XB+1)'(sh);
  end

  for (genvar k = 0; k < 4; k++) begin : g_addr
    assign ra_next[k] = (inx[k%2] && iny[k/2]) ?
        AW'(AW'(yn[k/2] >> 1) * AW'(HW) + AW'(xn[k%2] >> 1)) : '0;
  end

  assign ld_ok = (int'(in_item.cx) < SRC_MAX_W) && (int'(in_item.cy) < SRC_MAX_H);

  // address stage
  logic                 a_valid;
  bgs_pkg::item_t       a_item;
  logic [AW-1:0]        a_ra [4];
  logic [3:0]           a_white;
  logic                 a_xp, a_yp;
  logic [FRAC_BITS-1:0] a_xf, a_yf;
  logic                 a_we;
  logic [1:0]           a_wbank;
  logic [AW-1:0]        a_wa;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= in_item;
      for (int k = 0; k < 4; k++) begin
        a_ra[k]    <= ra_next[k];
        a_white[k] <= !(inx[k%2] && iny[k/2]);
      end
      a_xp    <= x0[0];
      a_yp    <= y0[0];
      a_xf    <= qx[FRAC_BITS-1:0];
      a_yf    <= qy[FRAC_BITS-1:0];
      a_we    <= in_valid && (in_item.op == bgs_pkg::OP_LOAD) && ld_ok;
      a_wbank <= {in_item.cy[0], in_item.cx[0]};
      a_wa    <= AW'(AW'(in_item.cy[7:1]) * AW'(HW) + AW'(in_item.cx[7:1]));
    end
  end

  // read stage: four banks, split by row and column parity
  logic [7:0]           rd [4];
  logic [3:0]           b_white;
  logic                 b_xp, b_yp;

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0] mem [BD];
    always_ff @(posedge clk) begin
      if (en && a_we && (a_wbank == 2'(k))) begin
        mem[a_wa] <= a_item.pix;
      end
      if (en) begin
        rd[k] <= mem[a_ra[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nb_valid <= 1'b0;
    end else if (en) begin
      nb_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nb_item <= a_item;
      b_white <= a_white;
      b_xp    <= a_xp;
      b_yp    <= a_yp;
      nb_xf   <= a_xf;
      nb_yf   <= a_yf;
    end
  end

  // neighbour d = dy*2+dx lives in bank {y0[0]^dy, x0[0]^dx}
  for (genvar d = 0; d < 4; d++) begin : g_nb
    logic [1:0] bank;
    assign bank  = {b_yp ^ d[1], b_xp ^ d[0]};
    assign nb[d] = b_white[bank] ? bgs_pkg::WHITE : rd[bank];
  end

endmodule

// File: sv/bgs_blend.sv
`timescale 1ns / 1ps
module bgs_blend #(
  parameter int FRAC_BITS = bgs_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  bgs_pkg::item_t       in_item,
  input  logic [7:0]           nb [4],
  input  logic [FRAC_BITS-1:0] xf,
  input  logic [FRAC_BITS-1:0] yf,
  input  logic [7:0]           thresh,
  output logic                 out_valid,
  output logic [7:0]           pixel,
  output logic [7:0]           px,
  output logic [7:0]           py
);

  localparam int BW = 8 + FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                     input logic [FRAC_BITS-1:0] f);
    logic [BW-1:0] s;
    s = BW'(a) * BW'(ONE - {1'b0, f}) + BW'(b) * BW'(f);
    return 8'(s >> FRAC_BITS);
  endfunction

  logic                 h_valid;
  bgs_pkg::item_t       h_item;
  logic [7:0]           c0, c1;
  logic [FRAC_BITS-1:0] h_yf;
  logic [7:0]           c;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      h_valid   <= in_valid;
      out_valid <= h_valid && (h_item.op == bgs_pkg::OP_COMPUTE);
    end
  end

  // horizontal pass
  always_ff @(posedge clk) begin
    if (en) begin
      h_item <= in_item;
      c0     <= mix(nb[0], nb[1], xf);
      c1     <= mix(nb[2], nb[3], xf);
      h_yf   <= yf;
    end
  end

  assign c = mix(c0, c1, h_yf);

  // vertical pass and threshold
  always_ff @(posedge clk) begin
    if (en) begin
      pixel <= (c > thresh) ? bgs_pkg::WHITE : c;
      px    <= h_item.cx;
      py    <= h_item.cy;
    end
  end

endmodule

// File: sv/bilinear_grey_scaler_threshold_top.sv
`timescale 1ns / 1ps
// channel  | dir | payload                                  | handshake
// item     | in  | operation, coord_x, coord_y, pixel_in    | valid/ready
// result   | out | pixel_out, out_x, out_y                  | valid/ready
// cfg      | in  | cfg_index, cfg_data                      | cfg_we only
//
// one item enters per cycle while no result is held; a compute item passes through
// input, product, 16 + FRAC_BITS divider stages, address, bank read and two blend
// stages; loads give no result
// the source store is four parity banks, so all four neighbours read at once
// rst is synchronous; it clears valid bits and resets config to its defaults, not the store
// a held result stalls the whole pipe in place; nothing is dropped
module bilinear_grey_scaler_threshold_top #(
  parameter int SRC_MAX_W = bgs_pkg::SRC_MAX_W_DEF,
  parameter int SRC_MAX_H = bgs_pkg::SRC_MAX_H_DEF,
  parameter int DST_MAX_W = bgs_pkg::DST_MAX_W_DEF,
  parameter int DST_MAX_H = bgs_pkg::DST_MAX_H_DEF,
  parameter int FRAC_BITS = bgs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgs_pkg::CFG_DATA_W-1:0] cfg_data,
  bgs_in_if.sink                         item,
  bgs_out_if.source                      result
);

  localparam int NW = 16 + FRAC_BITS;

  logic [7:0] src_width;
  logic [6:0] src_height;
  logic [8:0] dst_width, dst_height;
  logic [7:0] white_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width       <= 8'd128;
      src_height      <= 7'd64;
      dst_width       <= 9'd256;
      dst_height      <= 9'd256;
      white_threshold <= bgs_pkg::THRESH_RST;
    end else if (cfg_we) begin
      unique case (bgs_pkg::cfg_idx_t'(cfg_index))
        bgs_pkg::CFG_SRC_WIDTH:  src_width       <= cfg_data[7:0];
        bgs_pkg::CFG_SRC_HEIGHT: src_height      <= cfg_data[6:0];
        bgs_pkg::CFG_DST_WIDTH:  dst_width       <= cfg_data[8:0];
        bgs_pkg::CFG_DST_HEIGHT: dst_height      <= cfg_data[8:0];
        bgs_pkg::CFG_THRESHOLD:  white_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero reads as one, oversize as the maximum
  logic [7:0] sw;
  logic [6:0] sh;
  logic [8:0] dw, dh;

  assign sw = (src_width == '0) ? 8'd1 :
              ((int'(src_width) > SRC_MAX_W) ? 8'(SRC_MAX_W) : src_width);
  assign sh = (src_height == '0) ? 7'd1 :
              ((int'(src_height) > SRC_MAX_H) ? 7'(SRC_MAX_H) : src_height);
  assign dw = (dst_width == '0) ? 9'd1 :
              ((int'(dst_width) > DST_MAX_W) ? 9'(DST_MAX_W) : dst_width);
  assign dh = (dst_height == '0) ? 9'd1 :
              ((int'(dst_height) > DST_MAX_H) ? 9'(DST_MAX_H) : dst_height);

  logic adv;
  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;

  // input register
  logic           s0_valid;
  bgs_pkg::item_t s0_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item <= '{op: bgs_pkg::op_t'(item.operation), cx: item.coord_x,
                   cy: item.coord_y, pix: item.pixel_in};
    end
  end

  // scaled numerators
  logic           s1_valid;
  bgs_pkg::item_t s1_item;
  logic [NW-1:0]  nx, ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item <= s0_item;
      nx      <= (NW'(s0_item.cx) * NW'(sw)) << FRAC_BITS;
      ny      <= (NW'(s0_item.cy) * NW'(sh)) << FRAC_BITS;
    end
  end

  logic [NW-1:0] qx, qy;

  bgs_div #(.NW(NW), .DB(bgs_pkg::DEN_W)) u_div_x (
    .clk(clk), .en(adv), .num(nx), .den(dw), .quot(qx)
  );

  bgs_div #(.NW(NW), .DB(bgs_pkg::DEN_W)) u_div_y (
    .clk(clk), .en(adv), .num(ny), .den(dh), .quot(qy)
  );

  // items ride alongside the divider stages
  logic           dv [NW];
  bgs_pkg::item_t di [NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NW; k++) dv[k] <= 1'b0;
    end else if (adv) begin
      dv[0] <= s1_valid;
      for (int k = 1; k < NW; k++) dv[k] <= dv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      di[0] <= s1_item;
      for (int k = 1; k < NW; k++) di[k] <= di[k-1];
    end
  end

  logic                 nb_valid;
  bgs_pkg::item_t       nb_item;
  logic [7:0]           nb [4];
  logic [FRAC_BITS-1:0] nb_xf, nb_yf;

  bgs_store #(
    .SRC_MAX_W(SRC_MAX_W), .SRC_MAX_H(SRC_MAX_H), .FRAC_BITS(FRAC_BITS), .NW(NW)
  ) u_store (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(dv[NW-1]), .in_item(di[NW-1]), .qx(qx), .qy(qy), .sw(sw), .sh(sh),
    .nb_valid(nb_valid), .nb_item(nb_item), .nb(nb), .nb_xf(nb_xf), .nb_yf(nb_yf)
  );

  bgs_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(nb_valid), .in_item(nb_item), .nb(nb), .xf(nb_xf), .yf(nb_yf),
    .thresh(white_threshold),
    .out_valid(result.valid), .pixel(result.pixel_out),
    .px(result.out_x), .py(result.out_y)
  );

  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (!adv && s0_valid) |=> (s0_valid && $stable(s0_item)))
    else $error("input stage changed during stall");

  a_sizes_nonzero: assert property (@(posedge clk) disable iff (rst)
    (sw != '0) && (sh != '0) && (dw != '0) && (dh != '0))
    else $error("effective size is zero");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (adv && u_blend.h_valid && (u_blend.h_item.op == bgs_pkg::OP_LOAD)) |=>
    !result.valid)
    else $error("load produced a result");

endmodule

// File: tb/sv/tb_bilinear_grey_scaler_threshold_top.sv
`timescale 1ns / 1ps

class grey_scale_scoreboard;
  typedef struct {
    logic [7:0] pix;
    logic [7:0] x;
    logic [7:0] y;
  } dst_pixel_t;

  localparam int SW_MAX = bgs_pkg::SRC_MAX_W_DEF;
  localparam int SH_MAX = bgs_pkg::SRC_MAX_H_DEF;
  localparam int DW_MAX = bgs_pkg::DST_MAX_W_DEF;
  localparam int DH_MAX = bgs_pkg::DST_MAX_H_DEF;
  localparam int FB     = bgs_pkg::FRAC_BITS_DEF;

  logic [7:0] img [SW_MAX*SH_MAX];
  bit         loaded [SW_MAX*SH_MAX];
  logic [7:0] src_w_reg;
  logic [6:0] src_h_reg;
  logic [8:0] dst_w_reg;
  logic [8:0] dst_h_reg;
  logic [7:0] thresh_reg;
  dst_pixel_t pending_pixels [$];
  int         errors;
  int         matched;

  function new();
    src_w_reg  = 8'd128;
    src_h_reg  = 7'd64;
    dst_w_reg  = 9'd256;
    dst_h_reg  = 9'd256;
    thresh_reg = bgs_pkg::THRESH_RST;
    errors     = 0;
    matched    = 0;
  endfunction

  function void set_reg(bgs_pkg::cfg_idx_t idx, logic [8:0] d);
    case (idx)
      bgs_pkg::CFG_SRC_WIDTH:  src_w_reg  = d[7:0];
      bgs_pkg::CFG_SRC_HEIGHT: src_h_reg  = d[6:0];
      bgs_pkg::CFG_DST_WIDTH:  dst_w_reg  = d;
      bgs_pkg::CFG_DST_HEIGHT: dst_h_reg  = d;
      bgs_pkg::CFG_THRESHOLD:  thresh_reg = d[7:0];
      default: ;
    endcase
  endfunction

  function int clamp(int v, int m);
    if (v == 0) return 1;
    return (v > m) ? m : v;
  endfunction

  function int eff_sw(); return clamp(src_w_reg, SW_MAX); endfunction
  function int eff_sh(); return clamp(src_h_reg, SH_MAX); endfunction
  function int eff_dw(); return clamp(dst_w_reg, DW_MAX); endfunction
  function int eff_dh(); return clamp(dst_h_reg, DH_MAX); endfunction

  function longint src_pos(int c, int s, int d);
    return ((longint'(c) * s) << FB) / d;
  endfunction

  // a neighbour inside the image must have been loaded
  function bit covered(int cx, int cy);
    int x0, y0, x, y;
    x0 = int'(src_pos(cx, eff_sw(), eff_dw()) >> FB);
    y0 = int'(src_pos(cy, eff_sh(), eff_dh()) >> FB);
    for (int dy = 0; dy < 2; dy++)
      for (int dx = 0; dx < 2; dx++) begin
        x = x0 + dx;
        y = y0 + dy;
        if (x < eff_sw() && y < eff_sh() && !loaded[y*SW_MAX+x]) return 0;
      end
    return 1;
  endfunction

  function longint pix_at(longint x, longint y);
    if (x >= eff_sw() || y >= eff_sh()) return 255;
    return img[y*SW_MAX+x];
  endfunction

  function longint mix(longint a, longint b, longint f);
    return (a * ((longint'(1) << FB) - f) + b * f) >> FB;
  endfunction

  function void note(bgs_pkg::op_t op, logic [7:0] cx, logic [7:0] cy, logic [7:0] pix);
    longint xi, yi, x0, y0, xf, yf, top, bot, c;
    dst_pixel_t e;
    if (op == bgs_pkg::OP_LOAD) begin
      if (cx < SW_MAX && cy < SH_MAX) begin
        img[cy*SW_MAX+cx]    = pix;
        loaded[cy*SW_MAX+cx] = 1;
      end
      return;
    end
    xi  = src_pos(cx, eff_sw(), eff_dw());
    yi  = src_pos(cy, eff_sh(), eff_dh());
    x0  = xi >> FB;
    y0  = yi >> FB;
    xf  = xi & ((longint'(1) << FB) - 1);
    yf  = yi & ((longint'(1) << FB) - 1);
    top = mix(pix_at(x0, y0), pix_at(x0 + 1, y0), xf);
    bot = mix(pix_at(x0, y0 + 1), pix_at(x0 + 1, y0 + 1), xf);
    c   = mix(top, bot, yf);
    if (c > thresh_reg) c = 255;
    e.pix = c[7:0];
    e.x   = cx;
    e.y   = cy;
    pending_pixels.push_back(e);
  endfunction

  function void check(logic [7:0] pix, logic [7:0] x, logic [7:0] y);
    dst_pixel_t e;
    if (pending_pixels.size() == 0) begin
      $error("unexpected result pixel_out=%0d out_x=%0d out_y=%0d", pix, x, y);
      errors++;
      return;
    end
    e = pending_pixels.pop_front();
    matched++;
    if (pix !== e.pix) begin
      $error("pixel_out expected %0d actual %0d", e.pix, pix);
      errors++;
    end
    if (x !== e.x) begin
      $error("out_x expected %0d actual %0d", e.x, x);
      errors++;
    end
    if (y !== e.y) begin
      $error("out_y expected %0d actual %0d", e.y, y);
      errors++;
    end
  endfunction
endclass

module tb_bilinear_grey_scaler_threshold_top;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bgs_pkg::CFG_DATA_W-1:0] cfg_data;
  bit                             steady;
  int                             loads_sent;
  int                             computes_sent;
  int                             phases_run;

  bgs_in_if  item ();
  bgs_out_if result ();

  grey_scale_scoreboard sb;

  bilinear_grey_scaler_threshold_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item.sink),
    .result    (result.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10ms;
    $display("tb_bilinear_grey_scaler_threshold_top NOT OK");
    $finish;
  end

  // result side back-pressure
  always @(negedge clk) begin
    result.ready <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      sb.check(result.pixel_out, result.out_x, result.out_y);
  end

  // entered just after a falling edge, returns just after one
  task automatic send(bgs_pkg::op_t op, logic [7:0] cx, logic [7:0] cy,
                      logic [7:0] pix);
    while (!steady && $urandom_range(99) < 35) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.valid     <= 1'b1;
    item.operation <= op;
    item.coord_x   <= cx;
    item.coord_y   <= cy;
    item.pixel_in  <= pix;
    do @(posedge clk); while (item.ready !== 1'b1);
    sb.note(op, cx, cy, pix);
    if (op == bgs_pkg::OP_LOAD) loads_sent++;
    else computes_sent++;
    @(negedge clk);
  endtask

  task automatic try_compute(int cx, int cy);
    if (sb.covered(cx, cy)) send(bgs_pkg::OP_COMPUTE, 8'(cx), 8'(cy), 8'($urandom));
  endtask

  task automatic write_reg(bgs_pkg::cfg_idx_t idx, int d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d[bgs_pkg::CFG_DATA_W-1:0];
    sb.set_reg(idx, d[bgs_pkg::CFG_DATA_W-1:0]);
    @(negedge clk);
  endtask

  // drain the pipe so the registers can change while idle
  task automatic drain();
    item.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic fill_source();
    int rows;
    rows = 256 / sb.eff_sw();
    if (rows < 2) rows = 2;
    if (rows > sb.eff_sh()) rows = sb.eff_sh();
    for (int y = 0; y < rows; y++)
      for (int x = 0; x < sb.eff_sw(); x++)
        if (!sb.loaded[y*128+x]) send(bgs_pkg::OP_LOAD, 8'(x), 8'(y), 8'($urandom));
  endtask

  task automatic random_items(int n);
    int cx, cy, tries;
    repeat (n) begin
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(99) < 85)
          send(bgs_pkg::OP_LOAD, 8'($urandom_range(sb.eff_sw() - 1)),
               8'($urandom_range(sb.eff_sh() - 1)), 8'($urandom));
        else
          send(bgs_pkg::OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        tries = 0;
        do begin
          if ($urandom_range(99) < 75) begin
            cx = $urandom_range((sb.eff_dw() + 1 > 255) ? 255 : sb.eff_dw() + 1);
            cy = $urandom_range((sb.eff_dh() + 1 > 255) ? 255 : sb.eff_dh() + 1);
          end else begin
            cx = $urandom_range(255);
            cy = $urandom_range(255);
          end
          tries++;
        end while (!sb.covered(cx, cy) && tries < 100);
        try_compute(cx, cy);
      end
    end
  endtask

  task automatic phase(int sw, int sh, int dw, int dh, int thr, int n);
    drain();
    write_reg(bgs_pkg::CFG_SRC_WIDTH, sw);
    write_reg(bgs_pkg::CFG_SRC_HEIGHT, sh);
    write_reg(bgs_pkg::CFG_DST_WIDTH, dw);
    write_reg(bgs_pkg::CFG_DST_HEIGHT, dh);
    write_reg(bgs_pkg::CFG_THRESHOLD, thr);
    cfg_we <= 1'b0;
    fill_source();
    random_items(n);
    phases_run++;
  endtask

  initial begin
    int waited;
    sb             = new();
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    item.valid     = 1'b0;
    item.operation = 1'b0;
    item.coord_x   = '0;
    item.coord_y   = '0;
    item.pixel_in  = '0;
    result.ready   = 1'b0;
    steady         = 1'b0;
    loads_sent     = 0;
    computes_sent  = 0;
    phases_run     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at reset settings
    send(bgs_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0);
    send(bgs_pkg::OP_LOAD, 8'd1, 8'd0, 8'd255);
    send(bgs_pkg::OP_LOAD, 8'd0, 8'd1, 8'd255);
    send(bgs_pkg::OP_LOAD, 8'd1, 8'd1, 8'd0);
    send(bgs_pkg::OP_LOAD, 8'd0, 8'd63, 8'd90);
    send(bgs_pkg::OP_LOAD, 8'd1, 8'd63, 8'd17);
    send(bgs_pkg::OP_LOAD, 8'd127, 8'd63, 8'd255);
    send(bgs_pkg::OP_LOAD, 8'd127, 8'd0, 8'd33);
    send(bgs_pkg::OP_LOAD, 8'd127, 8'd1, 8'd44);
    // loads beyond the store are ignored
    send(bgs_pkg::OP_LOAD, 8'd128, 8'd0, 8'd1);
    send(bgs_pkg::OP_LOAD, 8'd0, 8'd64, 8'd2);
    send(bgs_pkg::OP_LOAD, 8'd255, 8'd255, 8'd3);
    try_compute(0, 0);
    try_compute(1, 0);
    try_compute(1, 1);
    try_compute(255, 0);
    try_compute(0, 255);
    try_compute(255, 255);
    try_compute(254, 1);
    fill_source();
    random_items(120);
    phases_run++;

    // steady stretch, no idling on either side
    steady = 1'b1;
    phase(4, 3, 9, 7, 255, 150);
    steady = 1'b0;
    phase(1, 1, 1, 1, 0, 80);
    phase(0, 0, 0, 0, 128, 80);
    phase(255, 127, 511, 511, 200, 150);
    phase(7, 5, 3, 2, 100, 100);
    phase(128, 1, 256, 1, 255, 120);
    phase(1, 64, 1, 256, 50, 120);
    phase(128, 64, 256, 256, 160, 100);
    repeat (5)
      phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 40),
            $urandom_range(1, 40), $urandom_range(255), 110);

    item.valid <= 1'b0;
    waited = 0;
    while (sb.pending_pixels.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (sb.pending_pixels.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_pixels.size());
      sb.errors++;
    end
    $display("covered %0d phases: %0d loads, %0d computes, %0d results compared",
             phases_run, loads_sent, computes_sent, sb.matched);
    if (sb.errors == 0) begin
      $display("tb_bilinear_grey_scaler_threshold_top OK");
    end else begin
      $display("tb_bilinear_grey_scaler_threshold_top NOT OK");
    end
    $finish;
  end
endmodule

// File: bilinear_grey_scaler_threshold_top.f
sv/bgs_pkg.sv
sv/bgs_if.sv
sv/bgs_div.sv
sv/bgs_store.sv
sv/bgs_blend.sv
sv/bilinear_grey_scaler_threshold_top.sv
tb/sv/tb_bilinear_grey_scaler_threshold_top.sv
